// File: hw/rtl/audio_channel_remix_macros.svh
// Assertion macros used by the checker file acr_checker.sv.
`ifndef AUDIO_CHANNEL_REMIX_MACROS_SVH
`define AUDIO_CHANNEL_REMIX_MACROS_SVH

// Antecedent implies consequent, checked on every rising clock edge out of reset.
`define ACR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Expression never holds out of reset.
`define ACR_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/acr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acr_pkg;

  localparam int NumCh      = 8;
  localparam int SampleW    = 16;
  localparam int CountW     = 4;
  localparam int TermW      = SampleW + 3;
  localparam int AccW       = 2 * SampleW + 4;
  localparam int CoefShift  = 15;
  localparam int WRt        = 23170;

  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;

  localparam logic [2:0] CH_FL  = 3'd0;
  localparam logic [2:0] CH_FR  = 3'd1;
  localparam logic [2:0] CH_C   = 3'd2;
  localparam logic [2:0] CH_LFE = 3'd3;
  localparam logic [2:0] CH_SL  = 3'd4;
  localparam logic [2:0] CH_SR  = 3'd5;
  localparam logic [2:0] CH_BL  = 3'd6;
  localparam logic [2:0] CH_BR  = 3'd7;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [TermW-1:0]   term_val_t;

  // One output is (a * 1 + h * 0.5 + r * 0.7071), rounded and saturated.
  typedef struct packed {
    term_val_t a;
    term_val_t h;
    term_val_t r;
  } term_t;

  // Canonical slot that feeds packed position k for a layout of oc channels.
  function automatic logic [2:0] pack_slot(input logic [CountW-1:0] oc,
                                           input logic [2:0] k);
    logic [2:0] slot;
    slot = CH_FL;
    case (oc)
      4'd2: slot = (k == 3'd1) ? CH_FR : CH_FL;
      4'd3: slot = (k < 3'd3) ? k : CH_FL;
      4'd4: begin
        case (k)
          3'd1:    slot = CH_FR;
          3'd2:    slot = CH_BL;
          3'd3:    slot = CH_BR;
          default: slot = CH_FL;
        endcase
      end
      4'd5: begin
        case (k)
          3'd1:    slot = CH_FR;
          3'd2:    slot = CH_C;
          3'd3:    slot = CH_SL;
          3'd4:    slot = CH_SR;
          default: slot = CH_FL;
        endcase
      end
      4'd6: slot = (k < 3'd6) ? k : CH_FL;
      4'd7: begin
        case (k)
          3'd0:    slot = CH_FL;
          3'd1:    slot = CH_FR;
          3'd2:    slot = CH_C;
          3'd7:    slot = CH_FL;
          default: slot = k + 3'd1;
        endcase
      end
      4'd8:    slot = k;
      default: slot = CH_FL;
    endcase
    return slot;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/audio_channel_remix.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel remix between 7.1-style layouts, one frame of eight Q1.15 samples per word.
// Input channel: raise start with the eight canonical slots (FL FR C LFE SL SR BL BR);
//   the word is taken at every edge where start is high and busy is low. busy stays low,
//   so a new frame may follow in every cycle.
// Result channel: done_o is high for exactly one cycle with out_slot_0_o..out_slot_7_o,
//   packed in the target layout order; slots beyond output_count read zero.
// Each frame passes the input register, then one pass of adders and one constant
//   multiply per slot into the result register. Throughput: one frame per cycle.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 input_count,
//   1 output_count); other indexes are ignored. Write only while no frame is in flight.
// Reset: both counts return to 2 (stereo passthrough) and no result is pending.
// The receiver cannot stall: every result is shown once, for one cycle.
module audio_channel_remix
  import acr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [CountW-1:0]   cfg_data_i,
  input  wire logic signed [SampleW-1:0] in_front_left_i,
  input  wire logic signed [SampleW-1:0] in_front_right_i,
  input  wire logic signed [SampleW-1:0] in_center_i,
  input  wire logic signed [SampleW-1:0] in_low_freq_i,
  input  wire logic signed [SampleW-1:0] in_side_left_i,
  input  wire logic signed [SampleW-1:0] in_side_right_i,
  input  wire logic signed [SampleW-1:0] in_back_left_i,
  input  wire logic signed [SampleW-1:0] in_back_right_i,
  output      logic                done_o,
  output      logic signed [SampleW-1:0] out_slot_0_o,
  output      logic signed [SampleW-1:0] out_slot_1_o,
  output      logic signed [SampleW-1:0] out_slot_2_o,
  output      logic signed [SampleW-1:0] out_slot_3_o,
  output      logic signed [SampleW-1:0] out_slot_4_o,
  output      logic signed [SampleW-1:0] out_slot_5_o,
  output      logic signed [SampleW-1:0] out_slot_6_o,
  output      logic signed [SampleW-1:0] out_slot_7_o
);

  localparam logic signed [AccW-1:0] RndHalf = AccW'(1 << (CoefShift - 1));
  localparam logic signed [AccW-1:0] CoefRt  = AccW'(WRt);
  localparam logic signed [AccW-CoefShift-1:0] SatHi =
    (AccW-CoefShift)'((1 << (SampleW - 1)) - 1);
  localparam logic signed [AccW-CoefShift-1:0] SatLo =
    (AccW-CoefShift)'(-(1 << (SampleW - 1)));

  logic [CountW-1:0] ic_q, oc_q;
  logic              valid_q, done_q;
  sample_t           s_q   [NumCh];
  sample_t           out_q [NumCh];
  sample_t           out_d [NumCh];
  term_val_t         e     [NumCh];
  term_t             canon [NumCh];
  term_t             t     [NumCh];
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= CountW'(2);
      oc_q <= CountW'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INPUT_COUNT:  ic_q <= cfg_data_i;
        CFG_OUTPUT_COUNT: oc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= accept;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q[CH_FL]  <= in_front_left_i;
      s_q[CH_FR]  <= in_front_right_i;
      s_q[CH_C]   <= in_center_i;
      s_q[CH_LFE] <= in_low_freq_i;
      s_q[CH_SL]  <= in_side_left_i;
      s_q[CH_SR]  <= in_side_right_i;
      s_q[CH_BL]  <= in_back_left_i;
      s_q[CH_BR]  <= in_back_right_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      e[i] = TermW'(s_q[i]);
    end
  end

  // Canonical frame for upmix.
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      canon[i] = '0;
    end
    if (ic_q == CountW'(1)) begin
      for (int i = 0; i < NumCh; i++) begin
        canon[i].a = e[CH_FL];
      end
      canon[CH_LFE] = '0;
    end else if (ic_q < CountW'(5)) begin
      canon[CH_FL].a = e[CH_FL];
      canon[CH_FR].a = e[CH_FR];
      if (ic_q == CountW'(3)) begin
        canon[CH_C].a = e[CH_C];
      end else begin
        canon[CH_C].r = e[CH_FL] + e[CH_FR];
      end
      canon[CH_SL].r = e[CH_FL] - e[CH_FR];
      canon[CH_SR].r = e[CH_FL] - e[CH_FR];
      canon[CH_BL].r = e[CH_FL] - e[CH_FR];
      canon[CH_BR].r = e[CH_FL] - e[CH_FR];
    end else begin
      for (int i = 0; i < 6; i++) begin
        canon[i].a = e[i];
      end
      canon[CH_BL].a = e[CH_SL];
      canon[CH_BR].a = e[CH_SR];
    end
  end

  // Weighted terms for each packed slot.
  always_comb begin
    for (int k = 0; k < NumCh; k++) begin
      t[k] = '0;
    end
    if (oc_q inside {[4'd1:4'd8]}) begin
      if (ic_q == oc_q) begin
        for (int k = 0; k < NumCh; k++) begin
          if (CountW'(k) < oc_q) begin
            t[k].a = e[pack_slot(oc_q, 3'(k))];
          end
        end
      end else if (oc_q < ic_q) begin
        case (oc_q)
          4'd1: begin
            t[0].a = e[CH_C];
            t[0].h = e[CH_SL] + e[CH_SR] + e[CH_BL] + e[CH_BR];
            t[0].r = e[CH_FL] + e[CH_FR];
          end
          4'd2: begin
            t[0].a = e[CH_FL];
            t[0].r = e[CH_C] + e[CH_SL] + e[CH_BL];
            t[1].a = e[CH_FR];
            t[1].r = e[CH_C] + e[CH_SR] + e[CH_BR];
          end
          4'd3: begin
            t[0].a = e[CH_FL];
            t[0].r = e[CH_SL] + e[CH_BL];
            t[1].a = e[CH_FR];
            t[1].r = e[CH_SR] + e[CH_BR];
            t[2].a = e[CH_C];
          end
          4'd4: begin
            t[0].a = e[CH_FL];
            t[0].r = e[CH_C];
            t[1].a = e[CH_FR];
            t[1].r = e[CH_C];
            t[2].a = e[CH_SL] + e[CH_BL];
            t[3].a = e[CH_SR] + e[CH_BR];
          end
          4'd5: begin
            t[0].a = e[CH_FL];
            t[1].a = e[CH_FR];
            t[2].a = e[CH_C];
            t[3].a = e[CH_SL] + e[CH_BL];
            t[4].a = e[CH_SR] + e[CH_BR];
          end
          4'd6: begin
            t[0].a = e[CH_FL];
            t[1].a = e[CH_FR];
            t[2].a = e[CH_C];
            t[3].a = e[CH_LFE];
            t[4].a = e[CH_SL] + e[CH_BL];
            t[5].a = e[CH_SR] + e[CH_BR];
          end
          4'd7: begin
            t[0].a = e[CH_FL];
            t[1].a = e[CH_FR];
            t[2].a = e[CH_C];
            t[3].a = e[CH_SL];
            t[4].a = e[CH_SR];
            t[5].a = e[CH_BL];
            t[6].a = e[CH_BR];
          end
          default: begin
            for (int k = 0; k < NumCh; k++) begin
              t[k].a = e[k];
            end
          end
        endcase
      end else begin
        for (int k = 0; k < NumCh; k++) begin
          if (CountW'(k) < oc_q) begin
            t[k] = canon[pack_slot(oc_q, 3'(k))];
          end
        end
      end
    end
  end

  // Scale, round half up and saturate each slot.
  always_comb begin
    logic signed [AccW-1:0]          acc;
    logic signed [AccW-CoefShift-1:0] q;
    for (int k = 0; k < NumCh; k++) begin
      acc = (AccW'(t[k].a) <<< CoefShift) + (AccW'(t[k].h) <<< (CoefShift - 1))
          + AccW'(t[k].r) * CoefRt + RndHalf;
      q = (AccW-CoefShift)'(acc >>> CoefShift);
      if (q > SatHi) begin
        out_d[k] = SampleW'(SatHi);
      end else if (q < SatLo) begin
        out_d[k] = SampleW'(SatLo);
      end else begin
        out_d[k] = SampleW'(q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_q) begin
      for (int k = 0; k < NumCh; k++) begin
        out_q[k] <= out_d[k];
      end
    end
  end

  assign done_o       = done_q;
  assign out_slot_0_o = out_q[0];
  assign out_slot_1_o = out_q[1];
  assign out_slot_2_o = out_q[2];
  assign out_slot_3_o = out_q[3];
  assign out_slot_4_o = out_q[4];
  assign out_slot_5_o = out_q[5];
  assign out_slot_6_o = out_q[6];
  assign out_slot_7_o = out_q[7];

endmodule

`default_nettype wire

// File: hw/rtl/acr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "audio_channel_remix_macros.svh"

module acr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  `ACR_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)
  `ACR_ASSERT_IMPLIES(a_word_done, clk_i, rst_ni, start && !busy, ##2 done_o)
  `ACR_ASSERT_IMPLIES(a_done_has_word, clk_i, rst_ni, done_o, $past(start && !busy, 2))

endmodule

bind audio_channel_remix acr_checker u_acr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

`default_nettype wire

// File: tb/audio_channel_remix_tb.sv
`timescale 1ns / 1ps

module audio_channel_remix_tb;
  import acr_pkg::*;

  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;
  localparam int GainOne      = 32768;
  localparam int GainHalf     = 16384;
  localparam int SettleCycles = 4;
  localparam int Phases       = 24;
  localparam int WordsPerPhase = 27;
  localparam logic [SampleW-1:0] PosFull = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic [SampleW-1:0] NegFull = {1'b1, {(SampleW-1){1'b0}}};

  typedef logic [NumCh-1:0][SampleW-1:0] frame_t;
  typedef logic [CountW-1:0] count_t;
  typedef struct packed {
    logic   typed;
    frame_t want;
  } note_t;
  typedef struct packed {
    count_t in_cnt;
    count_t out_cnt;
    frame_t word;
    logic   typed;
    frame_t want;
  } row_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       start      = 1'b0;
  logic       busy;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = '0;
  count_t     cfg_data_i = '0;
  frame_t     word_in    = '0;
  logic       done_o;
  logic signed [SampleW-1:0] out_slot_0_o, out_slot_1_o, out_slot_2_o, out_slot_3_o;
  logic signed [SampleW-1:0] out_slot_4_o, out_slot_5_o, out_slot_6_o, out_slot_7_o;

  count_t in_cnt  = 4'd2;
  count_t out_cnt = 4'd2;
  frame_t remix_q[$];
  note_t  note_q[$];
  row_t   rows[$];
  int     mismatches = 0;
  int     idle_pct   = 0;

  always #5 clk_i = ~clk_i;

  audio_channel_remix i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_front_left_i  (word_in[CH_FL]),
    .in_front_right_i (word_in[CH_FR]),
    .in_center_i      (word_in[CH_C]),
    .in_low_freq_i    (word_in[CH_LFE]),
    .in_side_left_i   (word_in[CH_SL]),
    .in_side_right_i  (word_in[CH_SR]),
    .in_back_left_i   (word_in[CH_BL]),
    .in_back_right_i  (word_in[CH_BR]),
    .done_o           (done_o),
    .out_slot_0_o     (out_slot_0_o),
    .out_slot_1_o     (out_slot_1_o),
    .out_slot_2_o     (out_slot_2_o),
    .out_slot_3_o     (out_slot_3_o),
    .out_slot_4_o     (out_slot_4_o),
    .out_slot_5_o     (out_slot_5_o),
    .out_slot_6_o     (out_slot_6_o),
    .out_slot_7_o     (out_slot_7_o)
  );

  function automatic frame_t frame_of(logic [SampleW-1:0] fl, fr, c, lfe, sl, sr, bl, br);
    return {br, bl, sr, sl, lfe, c, fr, fl};
  endfunction

  function automatic int pack_src(int n, int k);
    case (n)
      4:       return (k < 2) ? k : k + 4;
      5, 7:    return (k < 3) ? k : k + 1;
      default: return k;
    endcase
  endfunction

  function automatic int mix_weight(int n, int k, int ch);
    int w;
    w = 0;
    case (n)
      1: begin
        if (ch == CH_FL || ch == CH_FR) w = WRt;
        else if (ch == CH_C) w = GainOne;
        else if (ch != CH_LFE) w = GainHalf;
      end
      2: begin
        if (ch == k) w = GainOne;
        else if (ch == CH_C || ch == int'(CH_SL) + k || ch == int'(CH_BL) + k) w = WRt;
      end
      3: begin
        if (k == 2) w = (ch == CH_C) ? GainOne : 0;
        else if (ch == k) w = GainOne;
        else if (ch == int'(CH_SL) + k || ch == int'(CH_BL) + k) w = WRt;
      end
      4: begin
        if (k < 2) begin
          if (ch == k) w = GainOne;
          else if (ch == CH_C) w = WRt;
        end else if (ch == int'(CH_SL) + k - 2 || ch == int'(CH_BL) + k - 2) begin
          w = GainOne;
        end
      end
      5, 6: begin
        if (k < n - 2) w = (ch == k) ? GainOne : 0;
        else if (ch == int'(CH_SL) + k - (n - 2) || ch == int'(CH_BL) + k - (n - 2))
          w = GainOne;
      end
      default: w = (ch == pack_src(n, k)) ? GainOne : 0;
    endcase
    return w;
  endfunction

  function automatic sample_t round_sat(longint acc);
    longint v;
    longint top;
    top = (longint'(1) << (SampleW - 1)) - 1;
    v = (acc + (longint'(1) << (CoefShift - 1))) >>> CoefShift;
    if (v > top) v = top;
    else if (v < -top - 1) v = -top - 1;
    return sample_t'(v);
  endfunction

  function automatic frame_t remix_frame(frame_t f, count_t ic, count_t oc);
    longint s[NumCh];
    longint canon[NumCh];
    longint acc;
    frame_t r;
    int     n;
    r = '0;
    for (int i = 0; i < NumCh; i++) begin
      s[i] = longint'($signed(f[i]));
      canon[i] = 0;
    end
    if (oc >= 1 && oc <= NumCh) begin
      n = oc;
      if (ic == oc) begin
        for (int k = 0; k < n; k++) r[k] = SampleW'(s[pack_src(n, k)]);
      end else if (oc < ic) begin
        for (int k = 0; k < n; k++) begin
          acc = 0;
          for (int i = 0; i < NumCh; i++) acc += s[i] * mix_weight(n, k, i);
          r[k] = round_sat(acc);
        end
      end else begin
        if (ic == 1) begin
          for (int i = 0; i < NumCh; i++) canon[i] = s[CH_FL];
          canon[CH_LFE] = 0;
        end else if (ic < 5) begin
          canon[CH_FL] = s[CH_FL];
          canon[CH_FR] = s[CH_FR];
          canon[CH_C]  = (ic == 3) ? s[CH_C] : round_sat((s[CH_FL] + s[CH_FR]) * WRt);
          for (int i = CH_SL; i < NumCh; i++)
            canon[i] = round_sat((s[CH_FL] - s[CH_FR]) * WRt);
        end else begin
          for (int i = 0; i < CH_BL; i++) canon[i] = s[i];
          canon[CH_BL] = s[CH_SL];
          canon[CH_BR] = s[CH_SR];
        end
        for (int k = 0; k < n; k++) r[k] = SampleW'(canon[pack_src(n, k)]);
      end
    end
    return r;
  endfunction

  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return PosFull;
      1:       return NegFull;
      2:       return '0;
      3:       return SampleW'(int'($urandom_range(63)) - 32);
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    for (int i = 0; i < NumCh; i++) f[i] = rand_sample();
    return f;
  endfunction

  function automatic void add_row(int ic, int oc, frame_t f, logic typed = 1'b0,
                                  frame_t want = '0);
    rows.push_back(row_t'{count_t'(ic), count_t'(oc), f, typed, want});
  endfunction

  task automatic report(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : monitor
    frame_t got;
    frame_t want;
    note_t  nt;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INPUT_COUNT) in_cnt = cfg_data_i;
        else if (cfg_idx_i == CFG_OUTPUT_COUNT) out_cnt = cfg_data_i;
      end
      if (done_o !== 1'b0) begin
        got = {out_slot_7_o, out_slot_6_o, out_slot_5_o, out_slot_4_o,
               out_slot_3_o, out_slot_2_o, out_slot_1_o, out_slot_0_o};
        if (remix_q.size() == 0) begin
          report($sformatf("word %h with none expected", got));
        end else begin
          want = remix_q.pop_front();
          for (int k = 0; k < NumCh; k++)
            if (got[k] !== want[k])
              report($sformatf("out_slot_%0d got %h want %h", k, got[k], want[k]));
        end
      end
      if (start && busy === 1'b0 && note_q.size() != 0) begin
        nt = note_q.pop_front();
        remix_q.push_back(nt.typed ? nt.want : remix_frame(word_in, in_cnt, out_cnt));
      end
    end
  end

  task automatic send_word(frame_t f, logic typed, frame_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    note_q.push_back(note_t'{typed, want});
    start   <= 1'b1;
    word_in <= f;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (remix_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, count_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_counts(count_t ic, count_t oc);
    drain();
    write_reg(CFG_INPUT_COUNT, ic);
    write_reg(CFG_OUTPUT_COUNT, oc);
    write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, count_t'($urandom));
  endtask

  initial begin : stimulus
    row_t   r;
    count_t ic;
    count_t oc;
    frame_t ramp;

    ramp = frame_of(NegFull, PosFull, 16'h0001, 16'hFFFF, 16'h0123, 16'hFEDC,
                    16'h4000, 16'hC000);
    add_row(2, 2, frame_of(PosFull, NegFull, 16'h1111, 16'h2222, 16'h3333, 16'h4444,
                           16'h5555, 16'h6666), 1'b1,
            frame_of(PosFull, NegFull, '0, '0, '0, '0, '0, '0));
    add_row(2, 2, frame_of(NegFull, PosFull, PosFull, PosFull, NegFull, NegFull,
                           PosFull, NegFull), 1'b1,
            frame_of(NegFull, PosFull, '0, '0, '0, '0, '0, '0));
    add_row(8, 8, ramp, 1'b1, ramp);
    add_row(8, 1, {NumCh{PosFull}});
    add_row(8, 1, {NumCh{NegFull}});
    add_row(8, 2, frame_of(PosFull, NegFull, PosFull, '0, PosFull, NegFull, PosFull,
                           NegFull));
    add_row(8, 3, frame_of(16'h4000, 16'hC000, 16'h0001, 16'h7000, 16'h4000, 16'hC000,
                           16'h4000, 16'hC000));
    add_row(8, 4, frame_of(PosFull, NegFull, PosFull, PosFull, PosFull, NegFull,
                           16'h0001, 16'hFFFF));
    add_row(8, 5, ramp);
    add_row(8, 6, frame_of(PosFull, PosFull, PosFull, NegFull, PosFull, NegFull,
                           PosFull, NegFull));
    add_row(8, 7, ramp);
    add_row(15, 8, ramp);
    add_row(1, 8, frame_of(16'h1234, PosFull, NegFull, PosFull, NegFull, PosFull,
                           NegFull, PosFull), 1'b1,
            frame_of(16'h1234, 16'h1234, 16'h1234, '0, 16'h1234, 16'h1234, 16'h1234,
                     16'h1234));
    add_row(1, 4, ramp);
    add_row(2, 8, ramp);
    add_row(2, 8, {NumCh{PosFull}});
    add_row(3, 6, ramp);
    add_row(4, 7, frame_of(16'h0001, 16'h0000, 16'h5A5A, PosFull, NegFull, PosFull,
                           NegFull, PosFull));
    add_row(0, 5, frame_of(NegFull, NegFull, '0, '0, '0, '0, '0, '0));
    add_row(5, 8, ramp);
    add_row(6, 7, ramp);
    add_row(7, 6, ramp);
    add_row(2, 0, ramp, 1'b1, '0);
    add_row(2, 15, ramp, 1'b1, '0);
    add_row(9, 3, ramp);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 18;
    foreach (rows[i]) begin
      r = rows[i];
      if (r.in_cnt != in_cnt || r.out_cnt != out_cnt) set_counts(r.in_cnt, r.out_cnt);
      send_word(r.word, r.typed, r.want);
    end

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: begin ic = 4'd8;  oc = 4'd1;  end
        1: begin ic = 4'd1;  oc = 4'd8;  end
        2: begin ic = 4'd0;  oc = 4'd8;  end
        3: begin ic = 4'd15; oc = 4'd1;  end
        4: begin ic = 4'd8;  oc = 4'd0;  end
        5: begin ic = 4'd4;  oc = 4'd15; end
        default: begin
          ic = ($urandom_range(7) == 0) ? count_t'($urandom) : count_t'($urandom_range(8, 1));
          oc = ($urandom_range(7) == 0) ? count_t'($urandom) : count_t'($urandom_range(8, 1));
        end
      endcase
      case (p % 4)
        1:       idle_pct = 88;
        2:       idle_pct = 18;
        default: idle_pct = 0;
      endcase
      set_counts(ic, oc);
      for (int n = 0; n < WordsPerPhase; n++) send_word(rand_frame(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/acr_pkg.sv
hw/rtl/audio_channel_remix.sv
hw/rtl/acr_checker.sv
tb/audio_channel_remix_tb.sv
